// File: hw/rtl/ccb_pkg.sv
// Shared constants, types and helpers for the clipped color-key blit.
package ccb_pkg;

	// Coordinate and address geometry
	localparam int COORD_BITS   = 16;
	localparam int ADDRESS_BITS = 32;
	localparam int HALF_BITS    = 16;   // register half-field spacing
	localparam int PIX_BITS     = 15;   // pixel_x / pixel_y width
	localparam int IDX_BITS     = 8;
	localparam int CFG_IDX_BITS = 4;
	localparam int CFG_DATA_BITS = 64;

	// Working width for clipped coordinates; holds every intermediate sum
	localparam int CW = (COORD_BITS + 4 > 18) ? COORD_BITS + 4 : 18;
	// Width of row * pitch product
	localparam int PW = CW - 1 + HALF_BITS;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_SRC_ORIGIN = 4'd0,
		REG_SRC_EXTENT = 4'd1,
		REG_DST_ORIGIN = 4'd2,
		REG_SRC_SIZE   = 4'd3,
		REG_CLIP       = 4'd4,
		REG_DST_SIZE   = 4'd5,
		REG_PITCH      = 4'd6,
		REG_KEY        = 4'd7
	} cfg_reg_t;

	// Per-axis configuration, already extended to working width
	typedef struct packed {
		logic signed [CW-1:0] org;      // source rectangle origin
		logic signed [CW-1:0] ext;      // source rectangle size
		logic signed [CW-1:0] dorg;     // requested destination origin
		logic signed [CW-1:0] src_size; // source surface size
		logic signed [CW-1:0] corg;     // clip origin
		logic signed [CW-1:0] cext;     // clip size
		logic signed [CW-1:0] dst_size; // destination surface size
	} axis_cfg_t;

	// Per-axis clipped window plus the pixel coordinate riding along
	typedef struct packed {
		logic signed [CW-1:0] s;        // clipped source start
		logic signed [CW-1:0] w;        // clipped size
		logic signed [CW-1:0] d;        // clipped destination start
		logic signed [CW-1:0] o;        // configured destination origin
		logic [PIX_BITS-1:0]  p;        // pixel coordinate
	} axis_t;

	// Sign-extend a coordinate field to working width
	function automatic logic signed [CW-1:0] sext_c(input logic [COORD_BITS-1:0] v);
		return CW'(signed'(v));
	endfunction

	// Zero-extend a coordinate field to working width
	function automatic logic signed [CW-1:0] zext_c(input logic [COORD_BITS-1:0] v);
		return signed'({{(CW-COORD_BITS){1'b0}}, v});
	endfunction

	// Saturate to signed 16 bits
	function automatic logic [15:0] sat16(input logic signed [CW-1:0] v);
		logic signed [CW-1:0] hi;
		logic signed [CW-1:0] lo;
		hi = CW'(32767);
		lo = -CW'(32768);
		if (v > hi) begin
			return 16'h7FFF;
		end else if (v < lo) begin
			return 16'h8000;
		end
		return v[15:0];
	endfunction

	// Saturate to unsigned 15 bits
	function automatic logic [14:0] sat15(input logic signed [CW-1:0] v);
		logic signed [CW-1:0] hi;
		hi = CW'(32767);
		if (v < 0) begin
			return 15'd0;
		end else if (v > hi) begin
			return 15'h7FFF;
		end
		return v[14:0];
	endfunction

endpackage

// File: hw/rtl/clipped_colorkey_blit.sv
// Top level of the clipped color-key blit: config registers and pixel pipeline.
//
// One pixel word is taken in every clock (busy never rises) and its result
// word appears on the result ports after the seven register stages, held for
// exactly one cycle and marked by result_valid. The stages are four of
// per-axis clipping, one window test, one row-times-pitch multiply and one
// address add. The receiver cannot stall the pipeline.
// Configuration writes are always ready and must only be issued while no
// pixel is in flight.
module clipped_colorkey_blit (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write channel
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [ccb_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [ccb_pkg::CFG_DATA_BITS-1:0] cfg_data,
	// pixel command
	input  logic                              start,
	output logic                              busy,
	input  logic [ccb_pkg::PIX_BITS-1:0]      pixel_x,
	input  logic [ccb_pkg::PIX_BITS-1:0]      pixel_y,
	input  logic [ccb_pkg::IDX_BITS-1:0]      pixel_index,
	// result
	output logic                              result_valid,
	output logic                              write_enable,
	output logic [ccb_pkg::ADDRESS_BITS-1:0]  dest_address,
	output logic [ccb_pkg::IDX_BITS-1:0]      write_value,
	output logic signed [15:0]                written_x,
	output logic signed [15:0]                written_y,
	output logic [14:0]                       written_width,
	output logic [14:0]                       written_height
);
	import ccb_pkg::*;

	localparam int LAT = 7;

	// Configuration registers
	logic [31:0] src_org_q, src_ext_q, dst_org_q, src_size_q, dst_size_q;
	logic [63:0] clip_q;
	logic [15:0] pitch_q;
	logic [8:0]  key_q;

	assign cfg_ready = 1'b1;
	assign busy      = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_org_q  <= '0;
			src_ext_q  <= '0;
			dst_org_q  <= '0;
			src_size_q <= '0;
			clip_q     <= '0;
			dst_size_q <= '0;
			pitch_q    <= '0;
			key_q      <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SRC_ORIGIN: src_org_q  <= cfg_data[31:0];
				REG_SRC_EXTENT: src_ext_q  <= cfg_data[31:0];
				REG_DST_ORIGIN: dst_org_q  <= cfg_data[31:0];
				REG_SRC_SIZE:   src_size_q <= cfg_data[31:0];
				REG_CLIP:       clip_q     <= cfg_data;
				REG_DST_SIZE:   dst_size_q <= cfg_data[31:0];
				REG_PITCH:      pitch_q    <= cfg_data[15:0];
				REG_KEY:        key_q      <= cfg_data[8:0];
				default: begin
				end
			endcase
		end
	end

	// Per-axis views of the configuration
	axis_cfg_t cfg_x, cfg_y;

	assign cfg_x.org      = sext_c(src_org_q[HALF_BITS +: COORD_BITS]);
	assign cfg_x.ext      = sext_c(src_ext_q[HALF_BITS +: COORD_BITS]);
	assign cfg_x.dorg     = sext_c(dst_org_q[HALF_BITS +: COORD_BITS]);
	assign cfg_x.src_size = zext_c(src_size_q[HALF_BITS +: COORD_BITS]);
	assign cfg_x.corg     = sext_c(clip_q[3*HALF_BITS +: COORD_BITS]);
	assign cfg_x.cext     = sext_c(clip_q[HALF_BITS +: COORD_BITS]);
	assign cfg_x.dst_size = zext_c(dst_size_q[HALF_BITS +: COORD_BITS]);

	assign cfg_y.org      = sext_c(src_org_q[0 +: COORD_BITS]);
	assign cfg_y.ext      = sext_c(src_ext_q[0 +: COORD_BITS]);
	assign cfg_y.dorg     = sext_c(dst_org_q[0 +: COORD_BITS]);
	assign cfg_y.src_size = zext_c(src_size_q[0 +: COORD_BITS]);
	assign cfg_y.corg     = sext_c(clip_q[2*HALF_BITS +: COORD_BITS]);
	assign cfg_y.cext     = sext_c(clip_q[0 +: COORD_BITS]);
	assign cfg_y.dst_size = zext_c(dst_size_q[0 +: COORD_BITS]);

	// Stages 1-4: clipping per axis
	axis_t ax, ay;

	ccb_axis u_axis_x (
		.clk (clk),
		.cfg (cfg_x),
		.pix (pixel_x),
		.res (ax)
	);

	ccb_axis u_axis_y (
		.clk (clk),
		.cfg (cfg_y),
		.pix (pixel_y),
		.res (ay)
	);

	// Valid bits, one per stage
	logic [LAT-1:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LAT-2:0], start && !busy};
		end
	end

	// Pixel index rides alongside the axis stages
	logic [IDX_BITS-1:0] idx_s1, idx_s2, idx_s3, idx_s4;

	always_ff @(posedge clk) begin
		idx_s1 <= pixel_index;
		idx_s2 <= idx_s1;
		idx_s3 <= idx_s2;
		idx_s4 <= idx_s3;
	end

	// Stage 5: window test, destination row/column, written rectangle
	logic signed [CW-1:0] px_e, py_e;
	logic                 nonempty, in_win;

	assign px_e     = signed'(CW'(ax.p));
	assign py_e     = signed'(CW'(ay.p));
	assign nonempty = (ax.w > 0) && (ay.w > 0);
	assign in_win   = nonempty
		&& (px_e >= ax.s) && (px_e < ax.s + ax.w)
		&& (py_e >= ay.s) && (py_e < ay.s + ay.w);

	logic                 in_s5, we_s5;
	logic [CW-2:0]        row_s5, col_s5;
	logic [IDX_BITS-1:0]  idx_s5;
	logic [15:0]          wx_s5, wy_s5;
	logic [14:0]          ww_s5, wh_s5;

	logic signed [CW-1:0] row_c, col_c;

	assign row_c = ay.d + (py_e - ay.s);
	assign col_c = ax.d + (px_e - ax.s);

	always_ff @(posedge clk) begin
		in_s5  <= in_win;
		we_s5  <= in_win && !(key_q[8] && (key_q[7:0] == idx_s4));
		row_s5 <= row_c[CW-2:0];
		col_s5 <= col_c[CW-2:0];
		idx_s5 <= idx_s4;
		if (nonempty) begin
			wx_s5 <= sat16(ax.d);
			wy_s5 <= sat16(ay.d);
			ww_s5 <= sat15(ax.w);
			wh_s5 <= sat15(ay.w);
		end else begin
			wx_s5 <= 16'(ax.o);
			wy_s5 <= 16'(ay.o);
			ww_s5 <= '0;
			wh_s5 <= '0;
		end
	end

	// Stage 6: row times pitch
	logic [PW-1:0]       prod_s6;
	logic [CW-2:0]       col_s6;
	logic                in_s6, we_s6;
	logic [IDX_BITS-1:0] idx_s6;
	logic [15:0]         wx_s6, wy_s6;
	logic [14:0]         ww_s6, wh_s6;

	always_ff @(posedge clk) begin
		prod_s6 <= PW'(row_s5) * PW'(pitch_q);
		col_s6  <= col_s5;
		in_s6   <= in_s5;
		we_s6   <= we_s5;
		idx_s6  <= idx_s5;
		wx_s6   <= wx_s5;
		wy_s6   <= wy_s5;
		ww_s6   <= ww_s5;
		wh_s6   <= wh_s5;
	end

	// Stage 7: add column, gate address outside the window
	logic [PW-1:0]           sum_c;
	logic [ADDRESS_BITS-1:0] addr_s7;
	logic                    we_s7;
	logic [IDX_BITS-1:0]     idx_s7;
	logic [15:0]             wx_s7, wy_s7;
	logic [14:0]             ww_s7, wh_s7;

	assign sum_c = prod_s6 + PW'(col_s6);

	always_ff @(posedge clk) begin
		addr_s7 <= in_s6 ? sum_c[ADDRESS_BITS-1:0] : '0;
		we_s7   <= we_s6;
		idx_s7  <= idx_s6;
		wx_s7   <= wx_s6;
		wy_s7   <= wy_s6;
		ww_s7   <= ww_s6;
		wh_s7   <= wh_s6;
	end

	// Result word
	assign result_valid   = vld_q[LAT-1];
	assign write_enable   = we_s7;
	assign dest_address   = addr_s7;
	assign write_value    = idx_s7;
	assign written_x      = signed'(wx_s7);
	assign written_y      = signed'(wy_s7);
	assign written_width  = ww_s7;
	assign written_height = wh_s7;

endmodule

// File: hw/rtl/ccb_axis.sv
// Four-stage clipping pipeline for one axis: source surface, then clip window.
module ccb_axis (
	input  logic                          clk,
	input  ccb_pkg::axis_cfg_t            cfg,
	input  logic [ccb_pkg::PIX_BITS-1:0]  pix,
	output ccb_pkg::axis_t                res
);
	import ccb_pkg::*;

	logic signed [CW-1:0] s_s1, w_s1, d_s1, o_s1, c0_s1, c1r_s1;
	logic [PIX_BITS-1:0]  p_s1;
	logic signed [CW-1:0] s_s2, w_s2, d_s2, o_s2, c0_s2, c1_s2;
	logic [PIX_BITS-1:0]  p_s2;
	logic signed [CW-1:0] s_s3, w_s3, d_s3, o_s3, c1_s3;
	logic [PIX_BITS-1:0]  p_s3;
	logic signed [CW-1:0] s_s4, w_s4, d_s4, o_s4;
	logic [PIX_BITS-1:0]  p_s4;

	logic signed [CW-1:0] c1_raw;
	logic signed [CW-1:0] dd;

	assign c1_raw = cfg.corg + cfg.cext;
	assign dd     = c0_s2 - d_s2;

	// S1: negative source origin moves the destination; clip window low edge
	always_ff @(posedge clk) begin
		if (cfg.org < 0) begin
			s_s1 <= '0;
			w_s1 <= cfg.ext + cfg.org;
			d_s1 <= cfg.dorg - cfg.org;
		end else begin
			s_s1 <= cfg.org;
			w_s1 <= cfg.ext;
			d_s1 <= cfg.dorg;
		end
		c0_s1  <= (cfg.corg < 0) ? '0 : cfg.corg;
		c1r_s1 <= c1_raw;
		o_s1   <= cfg.dorg;
		p_s1   <= pix;
	end

	// S2: trim to source surface; clamp clip high edge to destination surface
	always_ff @(posedge clk) begin
		w_s2  <= (s_s1 + w_s1 > cfg.src_size) ? cfg.src_size - s_s1 : w_s1;
		c1_s2 <= (c1r_s1 > cfg.dst_size) ? cfg.dst_size : c1r_s1;
		s_s2  <= s_s1;
		d_s2  <= d_s1;
		c0_s2 <= c0_s1;
		o_s2  <= o_s1;
		p_s2  <= p_s1;
	end

	// S3: destination left of the clip edge
	always_ff @(posedge clk) begin
		if (d_s2 < c0_s2) begin
			s_s3 <= s_s2 + dd;
			w_s3 <= w_s2 - dd;
			d_s3 <= c0_s2;
		end else begin
			s_s3 <= s_s2;
			w_s3 <= w_s2;
			d_s3 <= d_s2;
		end
		c1_s3 <= c1_s2;
		o_s3  <= o_s2;
		p_s3  <= p_s2;
	end

	// S4: destination past the clip far edge
	always_ff @(posedge clk) begin
		w_s4 <= (d_s3 + w_s3 > c1_s3) ? c1_s3 - d_s3 : w_s3;
		s_s4 <= s_s3;
		d_s4 <= d_s3;
		o_s4 <= o_s3;
		p_s4 <= p_s3;
	end

	assign res.s = s_s4;
	assign res.w = w_s4;
	assign res.d = d_s4;
	assign res.o = o_s4;
	assign res.p = p_s4;

endmodule

// File: dv/tb_clipped_colorkey_blit.sv
// Self-checking testbench for the clipped color-key blit: predicts each pixel result and compares.
module tb_clipped_colorkey_blit;
	timeunit 1ns;
	timeprecision 1ps;

	import ccb_pkg::*;

	// one pixel word as sent to the block
	typedef struct packed {
		logic [PIX_BITS-1:0] x;
		logic [PIX_BITS-1:0] y;
		logic [IDX_BITS-1:0] idx;
	} pixel_word_t;

	// one result word as the block should return it
	typedef struct packed {
		logic                    we;
		logic [ADDRESS_BITS-1:0] addr;
		logic [IDX_BITS-1:0]     value;
		logic [15:0]             wx;
		logic [15:0]             wy;
		logic [14:0]             ww;
		logic [14:0]             wh;
	} blit_result_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;
	logic                     start = 1'b0;
	logic                     busy;
	logic [PIX_BITS-1:0]      pixel_x = '0;
	logic [PIX_BITS-1:0]      pixel_y = '0;
	logic [IDX_BITS-1:0]      pixel_index = '0;
	logic                     result_valid;
	logic                     write_enable;
	logic [ADDRESS_BITS-1:0]  dest_address;
	logic [IDX_BITS-1:0]      write_value;
	logic signed [15:0]       written_x;
	logic signed [15:0]       written_y;
	logic [14:0]              written_width;
	logic [14:0]              written_height;

	clipped_colorkey_blit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.start(start),
		.busy(busy),
		.pixel_x(pixel_x),
		.pixel_y(pixel_y),
		.pixel_index(pixel_index),
		.result_valid(result_valid),
		.write_enable(write_enable),
		.dest_address(dest_address),
		.write_value(write_value),
		.written_x(written_x),
		.written_y(written_y),
		.written_width(written_width),
		.written_height(written_height)
	);

	always #2 clk = ~clk;

	// testbench copy of the register file and the per-phase settings to load
	logic [63:0]  blit_regs [8];
	logic [63:0]  phase_cfg [8];
	pixel_word_t  pixel_q[$];
	blit_result_t expected_q[$];
	pixel_word_t  drv_word;
	blit_result_t mon_word;
	int           idle_pct = 0;
	int           n_errors = 0;
	int           n_results = 0;
	int           n_written = 0;
	int           n_keyed = 0;
	int           n_empty = 0;
	int           n_settings = 0;

	initial begin
		for (int i = 0; i < 8; i++) begin
			blit_regs[i] = '0;
			phase_cfg[i] = '0;
		end
	end

	// signed coordinate half of a register, COORD_BITS wide
	function automatic longint coord_s(logic [63:0] r, int shift);
		logic [63:0] v;
		v = (r >> shift) & ((64'd1 << COORD_BITS) - 64'd1);
		if (v[COORD_BITS-1])
			return longint'(v) - (longint'(1) << COORD_BITS);
		return longint'(v);
	endfunction

	// unsigned coordinate half of a register
	function automatic longint coord_u(logic [63:0] r, int shift);
		return longint'((r >> shift) & ((64'd1 << COORD_BITS) - 64'd1));
	endfunction

	function automatic logic [15:0] clamp_s16(longint v);
		if (v > 32767) return 16'h7FFF;
		if (v < -32768) return 16'h8000;
		return v[15:0];
	endfunction

	function automatic logic [14:0] clamp_u15(longint v);
		if (v < 0) return 15'd0;
		if (v > 32767) return 15'h7FFF;
		return v[14:0];
	endfunction

	// expected result for one pixel under the current register settings
	function automatic blit_result_t predict_blit(pixel_word_t p);
		longint sx, sy, sw, sh, ox, oy, dx, dy;
		longint srcw, srch, dstw, dsth, cx0, cy0, cx1, cy1, px, py, d;
		longint row, col;
		logic [63:0] pitch, key;
		logic empty;
		blit_result_t r;
		sx = coord_s(blit_regs[REG_SRC_ORIGIN], 16);
		sy = coord_s(blit_regs[REG_SRC_ORIGIN], 0);
		sw = coord_s(blit_regs[REG_SRC_EXTENT], 16);
		sh = coord_s(blit_regs[REG_SRC_EXTENT], 0);
		ox = coord_s(blit_regs[REG_DST_ORIGIN], 16);
		oy = coord_s(blit_regs[REG_DST_ORIGIN], 0);
		dx = ox;
		dy = oy;
		srcw = coord_u(blit_regs[REG_SRC_SIZE], 16);
		srch = coord_u(blit_regs[REG_SRC_SIZE], 0);
		dstw = coord_u(blit_regs[REG_DST_SIZE], 16);
		dsth = coord_u(blit_regs[REG_DST_SIZE], 0);
		cx0 = coord_s(blit_regs[REG_CLIP], 48);
		cy0 = coord_s(blit_regs[REG_CLIP], 32);
		cx1 = cx0 + coord_s(blit_regs[REG_CLIP], 16);
		cy1 = cy0 + coord_s(blit_regs[REG_CLIP], 0);
		pitch = blit_regs[REG_PITCH];
		key = blit_regs[REG_KEY];
		px = longint'(p.x);
		py = longint'(p.y);

		// clip source rectangle to the source surface
		if (sx < 0) begin dx -= sx; sw += sx; sx = 0; end
		if (sy < 0) begin dy -= sy; sh += sy; sy = 0; end
		if (sx + sw > srcw) sw = srcw - sx;
		if (sy + sh > srch) sh = srch - sy;

		// clamp clip window to the destination, then clip destination to it
		if (cx0 < 0) cx0 = 0;
		if (cy0 < 0) cy0 = 0;
		if (cx1 > dstw) cx1 = dstw;
		if (cy1 > dsth) cy1 = dsth;
		if (dx < cx0) begin d = cx0 - dx; sx += d; sw -= d; dx = cx0; end
		if (dy < cy0) begin d = cy0 - dy; sy += d; sh -= d; dy = cy0; end
		if (dx + sw > cx1) sw = cx1 - dx;
		if (dy + sh > cy1) sh = cy1 - dy;

		empty = (sw <= 0 || sh <= 0);
		r.we = 1'b0;
		r.addr = '0;
		r.value = p.idx;
		if (!empty && px >= sx && px < sx + sw && py >= sy && py < sy + sh) begin
			row = dy + (py - sy);
			col = dx + (px - sx);
			r.addr = ADDRESS_BITS'(row * longint'(pitch) + col);
			r.we = !(key[8] && key[7:0] == p.idx);
			if (!r.we)
				n_keyed++;
		end
		if (empty) begin
			r.wx = clamp_s16(ox);
			r.wy = clamp_s16(oy);
			r.ww = '0;
			r.wh = '0;
			n_empty++;
		end else begin
			r.wx = clamp_s16(dx);
			r.wy = clamp_s16(dy);
			r.ww = clamp_u15(sw);
			r.wh = clamp_u15(sh);
		end
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		n_errors++;
		if (n_errors <= 40)
			$display("ERROR at %0t ns: %s", $time, msg);
	endtask

	task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got 0x%0h, want 0x%0h", name, got, want));
	endtask

	// pixel driver: records each accepted word's prediction, then offers the next
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy)
				expected_q.push_back(predict_blit({pixel_x, pixel_y, pixel_index}));
			if (!start || !busy) begin
				if (pixel_q.size() > 0 && int'($urandom_range(0, 99)) >= idle_pct) begin
					drv_word = pixel_q.pop_front();
					start <= 1'b1;
					pixel_x <= drv_word.x;
					pixel_y <= drv_word.y;
					pixel_index <= drv_word.idx;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// result monitor: each strobed word against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && result_valid) begin
			n_results++;
			if (expected_q.size() == 0) begin
				report_mismatch("result word with no pixel outstanding");
			end else begin
				mon_word = expected_q.pop_front();
				if (mon_word.we)
					n_written++;
				check_field("write_enable", 32'(write_enable), 32'(mon_word.we));
				check_field("dest_address", dest_address, mon_word.addr);
				check_field("write_value", 32'(write_value), 32'(mon_word.value));
				check_field("written_x", {16'd0, written_x}, 32'(mon_word.wx));
				check_field("written_y", {16'd0, written_y}, 32'(mon_word.wy));
				check_field("written_width", 32'(written_width), 32'(mon_word.ww));
				check_field("written_height", 32'(written_height), 32'(mon_word.wh));
			end
		end
	end

	// one register write on the config channel
	task automatic write_reg(cfg_reg_t r, logic [63:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= r;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (r)
			REG_CLIP:  blit_regs[r] = v;
			REG_PITCH: blit_regs[r] = v & 64'hFFFF;
			REG_KEY:   blit_regs[r] = v & 64'h1FF;
			default:   blit_regs[r] = v & 64'hFFFF_FFFF;
		endcase
	endtask

	// load all eight registers from phase_cfg
	task automatic load_config();
		for (int i = 0; i < 8; i++)
			write_reg(cfg_reg_t'(i), phase_cfg[i]);
		n_settings++;
	endtask

	// block until every pixel word is sent and answered, then let the pipe drain
	task automatic wait_drained();
		do @(negedge clk); while (pixel_q.size() != 0 || start || expected_q.size() != 0);
		repeat (10) @(posedge clk);
	endtask

	function automatic logic [31:0] pair16(int hi, int lo);
		return {16'(hi), 16'(lo)};
	endfunction

	function automatic logic [63:0] clip_of(int cx, int cy, int cw, int ch);
		return {16'(cx), 16'(cy), 16'(cw), 16'(ch)};
	endfunction

	task automatic queue_pixel(int x, int y, int idx);
		pixel_word_t w;
		w.x = PIX_BITS'(x);
		w.y = PIX_BITS'(y);
		w.idx = IDX_BITS'(idx);
		pixel_q.push_back(w);
	endtask

	// random pixels, most of them near the source rectangle
	task automatic queue_random_pixels(int n);
		longint rx, ry, rw, rh, px, py;
		int idx;
		rx = coord_s(blit_regs[REG_SRC_ORIGIN], 16);
		ry = coord_s(blit_regs[REG_SRC_ORIGIN], 0);
		rw = coord_s(blit_regs[REG_SRC_EXTENT], 16);
		rh = coord_s(blit_regs[REG_SRC_EXTENT], 0);
		if (rw < 0) rw = 0;
		if (rh < 0) rh = 0;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) < 8) begin
				px = rx - 2 + longint'($urandom_range(0, int'(rw) + 4));
				py = ry - 2 + longint'($urandom_range(0, int'(rh) + 4));
				if (px < 0) px = longint'($urandom_range(0, 3));
				if (py < 0) py = longint'($urandom_range(0, 3));
				if (px > 32767) px = 32767;
				if (py > 32767) py = 32767;
			end else begin
				px = longint'($urandom_range(0, 32767));
				py = longint'($urandom_range(0, 32767));
			end
			idx = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 255))
				: int'($urandom_range(0, 7));
			queue_pixel(int'(px), int'(py), idx);
		end
	endtask

	// random settings; small surfaces unless wild, where every bit is random
	task automatic make_random_config(bit wild);
		int dstw;
		if (wild) begin
			for (int i = 0; i < 8; i++)
				phase_cfg[i] = {$urandom, $urandom};
		end else begin
			dstw = int'($urandom_range(1, 80));
			phase_cfg[REG_SRC_ORIGIN] = pair16(int'($urandom_range(0, 12)) - 4,
				int'($urandom_range(0, 12)) - 4);
			phase_cfg[REG_SRC_EXTENT] = pair16(int'($urandom_range(0, 40)) - 2,
				int'($urandom_range(0, 40)) - 2);
			phase_cfg[REG_DST_ORIGIN] = pair16(int'($urandom_range(0, 70)) - 10,
				int'($urandom_range(0, 70)) - 10);
			phase_cfg[REG_SRC_SIZE] = pair16(int'($urandom_range(1, 48)),
				int'($urandom_range(1, 48)));
			phase_cfg[REG_CLIP] = clip_of(int'($urandom_range(0, 48)) - 8,
				int'($urandom_range(0, 48)) - 8, int'($urandom_range(0, 70)) - 4,
				int'($urandom_range(0, 70)) - 4);
			phase_cfg[REG_DST_SIZE] = pair16(dstw, int'($urandom_range(1, 80)));
			case ($urandom_range(0, 9))
				0:       phase_cfg[REG_PITCH] = 64'd0;
				1:       phase_cfg[REG_PITCH] = 64'hFFFF;
				default: phase_cfg[REG_PITCH] = 64'(dstw + int'($urandom_range(0, 8)));
			endcase
			phase_cfg[REG_KEY] = {55'd0, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 7))};
		end
	endtask

	// stimulus: directed settings first, then random phases
	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// registers straight out of reset: empty window
		queue_pixel(0, 0, 0);
		queue_pixel(32767, 32767, 255);
		wait_drained();

		// plain blit with keying on index 5; edges, outside pixels, keyed pixel
		phase_cfg[REG_SRC_ORIGIN] = pair16(2, 3);
		phase_cfg[REG_SRC_EXTENT] = pair16(8, 6);
		phase_cfg[REG_DST_ORIGIN] = pair16(10, 5);
		phase_cfg[REG_SRC_SIZE]   = pair16(16, 16);
		phase_cfg[REG_CLIP]       = clip_of(0, 0, 64, 64);
		phase_cfg[REG_DST_SIZE]   = pair16(40, 30);
		phase_cfg[REG_PITCH]      = 64'd40;
		phase_cfg[REG_KEY]        = 64'h105;
		load_config();
		idle_pct = 54;
		queue_pixel(2, 3, 0);
		queue_pixel(9, 8, 255);
		queue_pixel(1, 3, 1);
		queue_pixel(10, 3, 1);
		queue_pixel(2, 2, 1);
		queue_pixel(2, 9, 1);
		queue_pixel(4, 4, 5);
		queue_pixel(5, 5, 6);
		queue_pixel(32767, 32767, 7);
		queue_pixel(0, 0, 7);
		wait_drained();

		// explicit all-zero settings
		for (int i = 0; i < 8; i++)
			phase_cfg[i] = '0;
		load_config();
		idle_pct = 0;
		queue_pixel(0, 0, 0);
		wait_drained();

		// all ones: negative extents and clip sizes give an empty window
		for (int i = 0; i < 8; i++)
			phase_cfg[i] = '1;
		load_config();
		queue_pixel(0, 0, 255);
		queue_pixel(32767, 32767, 255);
		wait_drained();

		// negative source origin and negative clip origin clamped to zero
		phase_cfg[REG_SRC_ORIGIN] = pair16(-3, -2);
		phase_cfg[REG_SRC_EXTENT] = pair16(12, 10);
		phase_cfg[REG_DST_ORIGIN] = pair16(-4, 1);
		phase_cfg[REG_SRC_SIZE]   = pair16(20, 20);
		phase_cfg[REG_CLIP]       = clip_of(-5, -5, 30, 20);
		phase_cfg[REG_DST_SIZE]   = pair16(25, 12);
		phase_cfg[REG_PITCH]      = 64'd25;
		phase_cfg[REG_KEY]        = 64'h003;
		load_config();
		idle_pct = 29;
		queue_pixel(0, 0, 3);
		queue_pixel(3, 4, 3);
		queue_pixel(8, 8, 9);
		wait_drained();

		// negative clip width: clip edge left of its origin
		phase_cfg[REG_CLIP] = clip_of(2, 0, -4, 20);
		load_config();
		queue_pixel(3, 4, 1);
		queue_pixel(8, 8, 2);
		wait_drained();

		// written x beyond 32767 saturates; uses the widest pitch
		phase_cfg[REG_SRC_ORIGIN] = pair16(-100, 0);
		phase_cfg[REG_SRC_EXTENT] = pair16(32767, 32767);
		phase_cfg[REG_DST_ORIGIN] = pair16(32767, 100);
		phase_cfg[REG_SRC_SIZE]   = pair16(65535, 65535);
		phase_cfg[REG_CLIP]       = clip_of(32767, 0, 32767, 32767);
		phase_cfg[REG_DST_SIZE]   = pair16(65535, 65535);
		phase_cfg[REG_PITCH]      = 64'hFFFF;
		phase_cfg[REG_KEY]        = 64'h1FF;
		load_config();
		idle_pct = 0;
		queue_pixel(0, 0, 255);
		queue_pixel(32666, 32766, 17);
		queue_pixel(32667, 5, 17);
		wait_drained();

		// junk above each register's width must be ignored
		phase_cfg[REG_SRC_ORIGIN] = {32'hDEAD_BEEF, pair16(1, 1)};
		phase_cfg[REG_SRC_EXTENT] = {32'hFFFF_FFFF, pair16(5, 5)};
		phase_cfg[REG_DST_ORIGIN] = {32'h1234_5678, pair16(3, 3)};
		phase_cfg[REG_SRC_SIZE]   = {32'h8000_0001, pair16(10, 10)};
		phase_cfg[REG_DST_SIZE]   = {32'hA5A5_A5A5, pair16(20, 20)};
		phase_cfg[REG_CLIP]       = clip_of(0, 0, 20, 20);
		phase_cfg[REG_PITCH]      = 64'hFFFF_FFFF_FFFF_0014;
		phase_cfg[REG_KEY]        = 64'hFFFF_FFFF_FFFF_FE02;
		load_config();
		idle_pct = 54;
		queue_pixel(2, 2, 2);
		queue_pixel(3, 4, 1);
		wait_drained();

		// random phases, rotating the sender's idle rate
		for (int ph = 0; ph < 9; ph++) begin
			make_random_config(ph == 3 || ph == 7);
			load_config();
			case (ph % 3)
				0:       idle_pct = 0;
				1:       idle_pct = 54;
				default: idle_pct = 29;
			endcase
			queue_random_pixels((ph == 3 || ph == 7) ? 50 : 100);
			wait_drained();
		end

		$display("checked %0d result words over %0d register settings", n_results, n_settings);
		$display("%0d writes, %0d keyed pixels, %0d on an empty window",
			n_written, n_keyed, n_empty);
		if (n_errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
